// ===== design/per_pixel_stack_median_top_macros.svh =====
// Assertion helpers for the pixel stack median block.
`ifndef PER_PIXEL_STACK_MEDIAN_TOP_MACROS_SVH
`define PER_PIXEL_STACK_MEDIAN_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define PPSM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppsm assertion failed");

// Checked on every clock edge, reset included.
`define PPSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppsm assertion failed");

`else

`define PPSM_ASSERT(lbl, clk, rst, prop)
`define PPSM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== design/ppsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppsm_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int SAMPLE_BITS = 8;
  localparam int CNT_W       = 4;
  localparam int RANK_W      = $clog2(MAX_FRAMES + 1);

  localparam logic [CNT_W-1:0] NUM_FRAMES_RST = CNT_W'(MAX_FRAMES);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [RANK_W-1:0]      rank_t;

endpackage

`default_nettype wire

// ===== design/ppsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ppsm_in_if;

  logic              valid;
  logic              ready;
  ppsm_pkg::sample_t sample0;
  ppsm_pkg::sample_t sample1;
  ppsm_pkg::sample_t sample2;
  ppsm_pkg::sample_t sample3;
  ppsm_pkg::sample_t sample4;
  ppsm_pkg::sample_t sample5;
  ppsm_pkg::sample_t sample6;
  ppsm_pkg::sample_t sample7;

  modport source (
    output valid, sample0, sample1, sample2, sample3,
    output sample4, sample5, sample6, sample7,
    input  ready
  );

  modport sink (
    input  valid, sample0, sample1, sample2, sample3,
    input  sample4, sample5, sample6, sample7,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/ppsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ppsm_out_if;

  logic              valid;
  logic              ready;
  ppsm_pkg::sample_t median_value;

  modport source (
    output valid, median_value,
    input  ready
  );

  modport sink (
    input  valid, median_value,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/per_pixel_stack_median_top.sv =====
// Temporal median of one pixel across up to eight stacked frames.
//
// stack  : sink channel; one transaction carries sample0..sample7, the
//          co-located gray values of one pixel from frames 0..7.
// result : source channel; one transaction carries median_value, the
//          sorted element at index n/2 of the first n samples (upper median
//          for even n).
// cfg_we / cfg_wdata : write of num_frames; 0 acts as 1, above 8 acts as 8.
//          Write only while no transaction is in flight.
//
// Pipeline: the accepting edge fills the input register, and the result
// register is filled from it after one rank-and-select pass once it has room.
// Throughput is one pixel per cycle while result is not stalled; the rank
// network (8x8 compares and popcounts) is the combinational path that sets it.
// A stalled result holds in its register; the input register keeps taking
// a transaction until both stages are full, then stack.ready drops.
// rst clears both stage valids and sets num_frames to 8.
`timescale 1ns / 1ps
`default_nettype none

`include "per_pixel_stack_median_top_macros.svh"

module per_pixel_stack_median_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire ppsm_pkg::count_t cfg_wdata,
  ppsm_in_if.sink             stack,
  ppsm_out_if.source          result
);

  import ppsm_pkg::*;

  count_t  num_frames;

  logic    s1_valid;
  sample_t s1_sample [MAX_FRAMES];
  logic    s2_valid;
  sample_t s2_median;

  logic    s1_load;
  logic    s1_advance;
  logic    s2_ready;

  rank_t   n_eff;
  rank_t   target;
  rank_t   rank [MAX_FRAMES];
  logic    [MAX_FRAMES-1:0] used;
  logic    [MAX_FRAMES-1:0] hit;
  sample_t median_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RST;
    end else if (cfg_we) begin
      num_frames <= cfg_wdata;
    end
  end

  always_comb begin
    if (num_frames > CNT_W'(MAX_FRAMES)) begin
      n_eff = RANK_W'(MAX_FRAMES);
    end else if (num_frames == '0) begin
      n_eff = RANK_W'(1);
    end else begin
      n_eff = RANK_W'(num_frames);
    end
    target = n_eff >> 1;
  end

  // handshake
  assign s2_ready     = !s2_valid || result.ready;
  assign s1_advance   = s1_valid && s2_ready;
  assign stack.ready  = !s1_valid || s2_ready;
  assign s1_load      = stack.valid && stack.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stack.ready) begin
      s1_valid <= stack.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sample[0] <= stack.sample0;
      s1_sample[1] <= stack.sample1;
      s1_sample[2] <= stack.sample2;
      s1_sample[3] <= stack.sample3;
      s1_sample[4] <= stack.sample4;
      s1_sample[5] <= stack.sample5;
      s1_sample[6] <= stack.sample6;
      s1_sample[7] <= stack.sample7;
    end
  end

  // rank every used sample; ties ordered by frame number
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      used[i] = RANK_W'(i) < n_eff;
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (used[j] && ((s1_sample[j] < s1_sample[i]) ||
                        ((s1_sample[j] == s1_sample[i]) && (j < i)))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
      hit[i] = used[i] && (rank[i] == target);
    end
  end

  // exactly one hit, so an OR of masked samples selects it
  always_comb begin
    median_next = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      median_next = median_next | (s1_sample[i] & {SAMPLE_BITS{hit[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_median <= median_next;
    end
  end

  assign result.valid        = s2_valid;
  assign result.median_value = s2_median;

  `PPSM_ASSERT(a_one_hit, clk, rst, s1_valid |-> $onehot(hit))
  `PPSM_ASSERT(a_count_range, clk, rst, (n_eff != '0) && (n_eff <= RANK_W'(MAX_FRAMES)))
  `PPSM_ASSERT(a_full_stall, clk, rst, (s1_valid && s2_valid && !result.ready) |-> !stack.ready)
  `PPSM_ASSERT(a_advance, clk, rst, s1_advance |=> s2_valid)
  `PPSM_ASSERT_ALWAYS(a_cfg_reset, clk, rst |=> (num_frames == NUM_FRAMES_RST))

endmodule

`default_nettype wire
